// ===== src/sgrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrtc_pkg
// Shared codes and constants for the ANSI SGR to text cell converter.
// ----------------------------------------------------------------------------
package sgrtc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ParamW = 10;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned OutDataW = 56;

  // parse modes
  localparam logic [ModeW-1:0] MODE_TEXT = 2'd0;
  localparam logic [ModeW-1:0] MODE_ESC  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SGR  = 2'd2;

  // result kinds
  localparam logic [KindW-1:0] KIND_CELL    = 2'd0;
  localparam logic [KindW-1:0] KIND_FILL    = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD_SGR = 2'd2;
  localparam logic [KindW-1:0] KIND_NO_BRKT = 2'd3;

  // register indexes
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_LIMIT = 1'b1;

  // stream bytes
  localparam logic [ByteW-1:0] CH_ESC   = 8'd27;
  localparam logic [ByteW-1:0] CH_LBRKT = 8'h5b;
  localparam logic [ByteW-1:0] CH_M     = 8'h6d;
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3b;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

  localparam logic [ByteW-1:0]  ROW_WIDTH_RST = 8'd80;
  localparam logic [ByteW-1:0]  ROW_LIMIT_RST = 8'd25;
  localparam logic [ParamW-1:0] PARAM_MAX     = 10'd999;
  localparam logic [ByteW-1:0]  ATTR_BRIGHT   = 8'h08;
  localparam logic [ByteW-1:0]  ATTR_BLINK    = 8'h80;
  localparam logic [ByteW-1:0]  COUNT_MAX     = 8'd255;

endpackage

// ===== src/ansi_sgr_to_text_cells.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_to_text_cells
// Turns an ANSI text byte stream into text-mode cells of character and
// attribute, parsing SGR escape sequences and padding rows on newline.
// The result is registered and reaches the output in the cycle after the accepting edge.
// Throughput: one byte per cycle; a byte is taken whenever the output register
// is empty or being drained, set by the single result register.
// Reset: synchronous; text mode, attribute, counters cleared, row width 80,
// row limit 25, no result pending.
// ----------------------------------------------------------------------------
module ansi_sgr_to_text_cells (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [sgrtc_pkg::OutDataW-1:0] m_tdata,
                                 // char_code, attribute, row, column, fill_count, bad_code, zeros
  output logic [1:0]  m_tuser,   // kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] row_width;
  logic [7:0] row_limit;

  logic [sgrtc_pkg::ModeW-1:0]  parse_mode, parse_mode_next;
  logic [7:0]                   current_attr, current_attr_next;
  logic [sgrtc_pkg::ParamW-1:0] param_value, param_value_next;
  logic                         param_ended, param_ended_next;
  logic [7:0]                   col_count, col_count_next;
  logic [7:0]                   row_count, row_count_next;

  logic                         out_valid;
  logic [sgrtc_pkg::KindW-1:0]  out_kind, res_kind;
  logic [7:0]                   out_char, res_char;
  logic [7:0]                   out_attr;
  logic [7:0]                   out_row;
  logic [7:0]                   out_col;
  logic [7:0]                   out_fill, res_fill;
  logic [sgrtc_pkg::ParamW-1:0] out_bad, res_bad;
  logic                         res_valid;

  logic        accept;
  logic        limit_hit;
  logic [7:0]  b;
  logic        is_digit;
  logic [13:0] acc_sum;
  logic [7:0]  applied_attr;
  logic        applied_bad;
  logic [9:0]  p_minus40;
  logic [9:0]  p_minus30;

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign b         = s_tdata;
  assign limit_hit = (row_count >= row_limit);
  assign is_digit  = (b >= sgrtc_pkg::CH_ZERO) && (b <= sgrtc_pkg::CH_NINE);
  assign acc_sum   = {1'b0, param_value, 3'b000} + {3'b000, param_value, 1'b0}
                     + {6'd0, b - sgrtc_pkg::CH_ZERO};
  assign p_minus40 = param_value - 10'd40;
  assign p_minus30 = param_value - 10'd30;

  // sgr parameter applied to the attribute
  always_comb begin
    applied_attr = current_attr;
    applied_bad  = 1'b0;
    if (param_value >= 10'd40) begin
      applied_attr = {p_minus40[3:0], current_attr[3:0]};
    end else if (param_value >= 10'd30) begin
      applied_attr = {current_attr[7:4], p_minus30[3:0]};
    end else if (param_value == 10'd1) begin
      applied_attr = current_attr | sgrtc_pkg::ATTR_BRIGHT;
    end else if (param_value == 10'd5) begin
      applied_attr = sgrtc_pkg::ATTR_BLINK;
    end else if (param_value == 10'd0) begin
      applied_attr = 8'd0;
    end else begin
      applied_bad = 1'b1;
    end
  end

  always_comb begin
    parse_mode_next   = parse_mode;
    current_attr_next = current_attr;
    param_value_next  = param_value;
    param_ended_next  = param_ended;
    col_count_next    = col_count;
    row_count_next    = row_count;
    res_valid         = 1'b0;
    res_kind          = sgrtc_pkg::KIND_CELL;
    res_char          = 8'd0;
    res_fill          = 8'd0;
    res_bad           = '0;
    if (!limit_hit) begin
      case (parse_mode)
        sgrtc_pkg::MODE_ESC: begin
          if (b == sgrtc_pkg::CH_LBRKT) begin
            parse_mode_next   = sgrtc_pkg::MODE_SGR;
            current_attr_next = 8'd0;
            param_value_next  = '0;
            param_ended_next  = 1'b0;
          end else begin
            parse_mode_next = sgrtc_pkg::MODE_TEXT;
            res_valid       = 1'b1;
            res_kind        = sgrtc_pkg::KIND_NO_BRKT;
            res_char        = b;
          end
        end
        sgrtc_pkg::MODE_SGR: begin
          if (b == sgrtc_pkg::CH_M || b == sgrtc_pkg::CH_SEMI) begin
            current_attr_next = applied_attr;
            param_value_next  = '0;
            param_ended_next  = 1'b0;
            if (b == sgrtc_pkg::CH_M) begin
              parse_mode_next = sgrtc_pkg::MODE_TEXT;
            end
            if (applied_bad) begin
              res_valid = 1'b1;
              res_kind  = sgrtc_pkg::KIND_BAD_SGR;
              res_bad   = param_value;
            end
          end else if (is_digit && !param_ended) begin
            param_value_next = (acc_sum > 14'(sgrtc_pkg::PARAM_MAX)) ?
                               sgrtc_pkg::PARAM_MAX : acc_sum[9:0];
          end else begin
            param_ended_next = 1'b1;
          end
        end
        default: begin
          parse_mode_next = sgrtc_pkg::MODE_TEXT;
          if (b == sgrtc_pkg::CH_ESC) begin
            parse_mode_next = sgrtc_pkg::MODE_ESC;
          end else if (b == sgrtc_pkg::CH_CR) begin
            res_valid = 1'b0;
          end else if (b == sgrtc_pkg::CH_LF) begin
            if (col_count != 8'd0 || row_count != 8'd0) begin
              res_valid      = 1'b1;
              res_kind       = sgrtc_pkg::KIND_FILL;
              res_fill       = (col_count < row_width) ? row_width - col_count : 8'd0;
              col_count_next = 8'd0;
              if (row_count != sgrtc_pkg::COUNT_MAX) begin
                row_count_next = row_count + 8'd1;
              end
            end
          end else begin
            res_valid = 1'b1;
            res_kind  = sgrtc_pkg::KIND_CELL;
            res_char  = b;
            if (col_count != sgrtc_pkg::COUNT_MAX) begin
              col_count_next = col_count + 8'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= sgrtc_pkg::ROW_WIDTH_RST;
      row_limit <= sgrtc_pkg::ROW_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sgrtc_pkg::REG_ROW_WIDTH: row_width <= cfg_data;
        sgrtc_pkg::REG_ROW_LIMIT: row_limit <= cfg_data;
        default: row_width <= row_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode   <= sgrtc_pkg::MODE_TEXT;
      current_attr <= 8'd0;
      param_value  <= '0;
      param_ended  <= 1'b0;
      col_count    <= 8'd0;
      row_count    <= 8'd0;
    end else if (accept) begin
      parse_mode   <= parse_mode_next;
      current_attr <= current_attr_next;
      param_value  <= param_value_next;
      param_ended  <= param_ended_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, attribute as it stands after the item, row and column before it
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind <= res_kind;
      out_char <= res_char;
      out_attr <= current_attr_next;
      out_row  <= row_count;
      out_col  <= col_count;
      out_fill <= res_fill;
      out_bad  <= res_bad;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_bad, out_fill, out_col, out_row, out_attr, out_char};

  a_param_sat: assert property (@(posedge clk) disable iff (rst)
    param_value <= sgrtc_pkg::PARAM_MAX)
    else $error("sgr parameter above saturation value");

  a_limit_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && limit_hit |-> !res_valid && row_count_next == row_count)
    else $error("item past row limit changed state or gave a result");

  a_fill_resets_col: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res_kind == sgrtc_pkg::KIND_FILL |=> col_count == 8'd0)
    else $error("column not cleared after row fill");

  a_bad_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == sgrtc_pkg::KIND_BAD_SGR |->
      out_bad >= 10'd2 && out_bad <= 10'd29 && out_bad != 10'd5)
    else $error("unsupported code result carries a supported code");

  a_fill_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == sgrtc_pkg::KIND_FILL |-> out_char == 8'd0)
    else $error("row fill carries a character");

endmodule
